// ----- rtl/keypad_code_lock_assert.svh -----
// assertion macros used by the entry core
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KCL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define KCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/kcl_pkg.sv -----
`default_nettype none
package kcl_pkg;

   localparam int unsigned NumDigits = 4;
   localparam int unsigned NumRows   = 3;
   localparam int unsigned NumCols   = 4;

   localparam logic [3:0] NonDigit = 4'd10;
   localparam logic [3:0] FailSat  = 4'd15;

   // register indexes of the configuration port
   localparam logic [2:0] RegCodeDigit0 = 3'd0;
   localparam logic [2:0] RegCodeDigit1 = 3'd1;
   localparam logic [2:0] RegCodeDigit2 = 3'd2;
   localparam logic [2:0] RegCodeDigit3 = 3'd3;
   localparam logic [2:0] RegMaxFailures = 3'd4;

   // reset values of the configuration registers
   localparam logic [3:0] CodeReset [NumDigits] = '{4'd5, 4'd7, 4'd1, 4'd3};
   localparam logic [3:0] MaxFailuresReset = 4'd3;

   // key value by row and column
   localparam logic [3:0] KeyMap [NumRows][NumCols] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3},
      '{4'd4, 4'd5, 4'd6, 4'd7},
      '{4'd8, 4'd9, NonDigit, NonDigit}
   };

   // one decoded key press
   typedef struct packed {
      logic       scan_error;
      logic [3:0] key_value;
   } key_info_type;

   // lock configuration
   typedef struct packed {
      logic [3:0][3:0] code_digit;
      logic [3:0]      max_failures;
   } lock_cfg_type;

   // one result word
   typedef struct packed {
      logic [3:0][3:0] shown_digit;
      logic [3:0]      failure_count;
      logic            alarm;
      logic            unlock;
      logic [1:0]      entry_count;
      logic [3:0]      key_value;
      logic            scan_error;
   } lock_result_type;

endpackage
`default_nettype wire

// ----- rtl/keypad_code_lock.sv -----
// Four-digit keypad combination lock. Each req_ word is one debounced press given as
// the sampled active-low row and column lines of a 3x4 keypad; each press yields one
// rsp_ word. The press is held in an input register, decoded and checked against the
// code in a single pass, and the outcome lands in a result register; one press is
// taken every cycle while rsp_tready is high. While a result waits on rsp_tready the
// input register holds one more press and then req_tready stays low; rsp_tready
// reaches req_tready through combinational logic. The csr_ port writes the code
// digits (index 0 to 3) and the failure limit (index 4); the user must write them only
// while the block is idle, which the block itself does not enforce. Other indexes are
// ignored.
`default_nettype none
module keypad_code_lock (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // row_lines[2:0], column_lines[6:3], zero [7]
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // key_value[3:0], entry_count[5:4], unlock[6],
                                        // alarm[7], failure_count[11:8],
                                        // shown_digit_0..3[27:12], zero [31:28]
   output logic             rsp_tuser,  // scan_error[0]
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);
   import kcl_pkg::*;

   logic            in_valid_ff;
   logic [2:0]      row_ff;
   logic [3:0]      col_ff;
   logic            key_take;
   key_info_type    key_info;
   lock_cfg_type    cfg_ff;
   lock_result_type result;

   // input register
   assign req_tready = !in_valid_ff || key_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         row_ff <= req_tdata[2:0];
         col_ff <= req_tdata[6:3];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_digit[0] <= CodeReset[0];
         cfg_ff.code_digit[1] <= CodeReset[1];
         cfg_ff.code_digit[2] <= CodeReset[2];
         cfg_ff.code_digit[3] <= CodeReset[3];
         cfg_ff.max_failures  <= MaxFailuresReset;
      end else if (csr_we) begin
         case (csr_index)
            RegCodeDigit0: begin
               cfg_ff.code_digit[0] <= csr_wdata;
            end
            RegCodeDigit1: begin
               cfg_ff.code_digit[1] <= csr_wdata;
            end
            RegCodeDigit2: begin
               cfg_ff.code_digit[2] <= csr_wdata;
            end
            RegCodeDigit3: begin
               cfg_ff.code_digit[3] <= csr_wdata;
            end
            RegMaxFailures: begin
               cfg_ff.max_failures <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   kcl_key_decode u_decode (
      .row_lines    (row_ff),
      .column_lines (col_ff),
      .key_info     (key_info)
   );

   kcl_entry_core u_core (
      .clock        (clock),
      .reset        (reset),
      .key_valid    (in_valid_ff),
      .key_info     (key_info),
      .lock_cfg     (cfg_ff),
      .key_take     (key_take),
      .result_valid (rsp_tvalid),
      .result       (result),
      .result_ready (rsp_tready)
   );

   // response packing
   assign rsp_tuser = result.scan_error;
   assign rsp_tdata = {4'd0,
                       result.shown_digit[3], result.shown_digit[2],
                       result.shown_digit[1], result.shown_digit[0],
                       result.failure_count, result.alarm, result.unlock,
                       result.entry_count, result.key_value};

endmodule
`default_nettype wire

// ----- rtl/kcl_key_decode.sv -----
`default_nettype none
module kcl_key_decode (
   input  wire logic [2:0]           row_lines,
   input  wire logic [3:0]           column_lines,
   output kcl_pkg::key_info_type     key_info
);
   import kcl_pkg::*;

   logic       row_found;
   logic       col_found;
   logic [1:0] row_idx;
   logic [1:0] col_idx;

   // lowest low row line wins
   always_comb begin
      row_found = 1'b1;
      row_idx   = 2'd0;
      if (!row_lines[0]) begin
         row_idx = 2'd0;
      end else if (!row_lines[1]) begin
         row_idx = 2'd1;
      end else if (!row_lines[2]) begin
         row_idx = 2'd2;
      end else begin
         row_found = 1'b0;
      end
   end

   // lowest low column line wins
   always_comb begin
      col_found = 1'b1;
      col_idx   = 2'd0;
      if (!column_lines[0]) begin
         col_idx = 2'd0;
      end else if (!column_lines[1]) begin
         col_idx = 2'd1;
      end else if (!column_lines[2]) begin
         col_idx = 2'd2;
      end else if (!column_lines[3]) begin
         col_idx = 2'd3;
      end else begin
         col_found = 1'b0;
      end
   end

   // key lookup, zero on a scan error
   always_comb begin
      key_info.scan_error = !(row_found && col_found);
      key_info.key_value  = 4'd0;
      if (row_found && col_found) begin
         key_info.key_value = KeyMap[row_idx][col_idx];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/kcl_entry_core.sv -----
`default_nettype none
`include "keypad_code_lock_assert.svh"
module kcl_entry_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    key_valid,
   input  wire kcl_pkg::key_info_type   key_info,
   input  wire kcl_pkg::lock_cfg_type   lock_cfg,
   output logic                         key_take,
   output logic                         result_valid,
   output kcl_pkg::lock_result_type     result,
   input  wire logic                    result_ready
);
   import kcl_pkg::*;

   logic [3:0][3:0] digits_ff, digits_in;
   logic [1:0]      pos_ff, pos_in;
   logic [3:0]      fail_ff, fail_in;
   logic            out_valid_ff, out_valid_in;
   lock_result_type out_ff, out_in;

   logic            complete;
   logic            match;
   logic [3:0]      fail_inc;

   // a key moves on when the result register is free or being emptied
   assign key_take = key_valid && (!out_valid_ff || result_ready);

   assign complete = !key_info.scan_error && (pos_ff == 2'd3);
   assign match    = (digits_ff[0] == lock_cfg.code_digit[0])
                  && (digits_ff[1] == lock_cfg.code_digit[1])
                  && (digits_ff[2] == lock_cfg.code_digit[2])
                  && (key_info.key_value == lock_cfg.code_digit[3]);
   assign fail_inc = fail_ff + 4'd1;

   // entry state update and result word
   always_comb begin
      digits_in = digits_ff;
      pos_in    = pos_ff;
      fail_in   = fail_ff;
      out_in    = out_ff;
      out_in.unlock = 1'b0;
      out_in.alarm  = 1'b0;
      if (!key_info.scan_error) begin
         if (complete) begin
            digits_in = '0;
            pos_in    = 2'd0;
            if (match) begin
               out_in.unlock = 1'b1;
            end else if (fail_ff < FailSat) begin
               fail_in      = fail_inc;
               out_in.alarm = (fail_inc == lock_cfg.max_failures);
            end
         end else begin
            digits_in[pos_ff] = key_info.key_value;
            pos_in            = pos_ff + 2'd1;
         end
      end
      out_in.scan_error    = key_info.scan_error;
      out_in.key_value     = key_info.key_value;
      out_in.entry_count   = pos_in;
      out_in.failure_count = fail_in;
      out_in.shown_digit   = digits_in;
   end

   // result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (key_take) begin
         out_valid_in = 1'b1;
      end else if (result_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= '0;
         pos_ff       <= 2'd0;
         fail_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (key_take) begin
            digits_ff <= digits_in;
            pos_ff    <= pos_in;
            fail_ff   <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_take) begin
         out_ff <= out_in;
      end
   end

   assign result_valid = out_valid_ff;
   assign result       = out_ff;

   // checks
   `KCL_ASSERT_IMPL(a_unlock_alarm_excl, clock, reset, out_valid_ff,
      !(out_ff.unlock && out_ff.alarm), "unlock and alarm in one word")
   `KCL_ASSERT_IMPL(a_scan_error_quiet, clock, reset, out_valid_ff && out_ff.scan_error,
      !out_ff.unlock && !out_ff.alarm && out_ff.key_value == 4'd0,
      "scan error word carries a key or a pulse")
   `KCL_ASSERT_NEXT(a_entry_cleared, clock, reset, key_take && complete,
      pos_ff == 2'd0 && digits_ff == '0, "entry not cleared after fourth key")
   `KCL_ASSERT_IMPL(a_fail_monotonic, clock, reset, !$past(reset),
      fail_ff >= $past(fail_ff), "failure count went down")

endmodule
`default_nettype wire
